// ----- rtl/core/dbsfe_pkg.sv -----
// Shared types, constants and the CRC-8 step of the door bus slave frame engine.
`default_nettype none

package dbsfe_pkg;

    // Bus protocol constants.
    localparam logic [7:0]  CRC_INIT       = 8'hF3;
    localparam logic [7:0]  CRC_POLY       = 8'h07;
    localparam logic [7:0]  HOST_ADDRESS   = 8'h80;
    localparam logic [7:0]  BCAST_ADDRESS  = 8'h00;
    localparam logic [7:0]  OP_SCAN        = 8'h01;
    localparam logic [7:0]  OP_STATUS_REQ  = 8'h20;
    localparam logic [7:0]  OP_STATUS_RESP = 8'h29;
    localparam logic [3:0]  SCAN_LEN_CODE  = 4'h2;
    localparam logic [3:0]  STAT_LEN_CODE  = 4'h3;
    localparam logic [3:0]  LEN_BCAST      = 4'd2;
    localparam logic [3:0]  LEN_SCAN       = 4'd2;
    localparam logic [3:0]  LEN_STATUS     = 4'd1;
    localparam logic [4:0]  LEN_OVERHEAD   = 5'd3;
    localparam logic [4:0]  POS_LENGTH     = 5'd2;
    localparam logic [4:0]  HDR_DEPTH      = 5'd4;

    // Pending action words.
    localparam logic [15:0] WORD_DEFAULT   = 16'h1000;
    localparam logic [15:0] WORD_STOP      = 16'h0000;
    localparam logic [15:0] WORD_OPEN      = 16'h1001;
    localparam logic [15:0] WORD_CLOSE     = 16'h1002;
    localparam logic [15:0] WORD_VENT      = 16'h1010;
    localparam logic [15:0] WORD_LIGHT     = 16'h1008;

    // Register reset values.
    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h28;
    localparam logic [7:0]  DEV_TYPE_RST   = 8'h14;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_TYPE   = 2'd1;

    // Input command codes.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TRIGGER = 1'b1;

    // Door action codes.
    localparam logic [2:0] ACT_STOP  = 3'd0;
    localparam logic [2:0] ACT_OPEN  = 3'd1;
    localparam logic [2:0] ACT_CLOSE = 3'd2;
    localparam logic [2:0] ACT_VENT  = 3'd3;
    localparam logic [2:0] ACT_LIGHT = 3'd4;

    // Result kinds.
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Reply sequencer steps.
    localparam logic [2:0] STEP_FIRST    = 3'd0;
    localparam logic [2:0] STEP_LEN      = 3'd1;
    localparam logic [2:0] STEP_OP       = 3'd2;
    localparam logic [2:0] STEP_DATA0    = 3'd3;
    localparam logic [2:0] STEP_DATA1    = 3'd4;
    localparam logic [2:0] STEP_SCAN_END = 3'd4;
    localparam logic [2:0] STEP_STAT_END = 3'd5;

    // Job queue geometry.
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        JOB_BCAST = 2'd0,
        JOB_SCAN  = 2'd1,
        JOB_STAT  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [3:0]  roll;
        logic [15:0] word;
    } job_t;

    // Front to queue write side.
    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

    // One byte through the CRC-8, MSB first.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dbsfe_in_if.sv -----
// Input channel: received bus bytes and door action triggers.
`default_nettype none

interface dbsfe_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic [2:0] action;

    modport source (output valid, cmd, rx_byte, framing_error, action, input ready);
    modport sink   (input valid, cmd, rx_byte, framing_error, action, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dbsfe_out_if.sv -----
// Output channel: reply bytes and broadcast status words.
`default_nettype none

interface dbsfe_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic [15:0] status_word;
    logic        last;

    modport source (output valid, kind, tx_byte, status_word, last, input ready);
    modport sink   (input valid, kind, tx_byte, status_word, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dbsfe_cfg_if.sv -----
// Configuration write channel.
`default_nettype none

interface dbsfe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/door_bus_slave_frame_engine_top.sv -----
// Top level of the door bus slave frame engine: registers and block wiring.
//
// req carries one beat per received bus byte or door action trigger. A byte
// flagged with a framing error is a break and starts frame capture; the
// frame's CRC-8 is checked as its bytes arrive. rsp carries reply bytes
// (kind 0) with the CRC byte flagged last, or a single broadcast status word
// (kind 1). cfg writes the slave address (index 0) and device type (index 1);
// it is always ready and must only be used while the block is idle.
// req takes one beat per cycle as long as the four-entry job queue has room;
// a frame that needs no answer never fills it. A finished frame's job
// passes through the queue and the output register. A scan reply runs five
// beats and a status reply six, one per cycle while rsp is ready, bounded by
// the reply sequencer that forms one byte and one CRC step per cycle.
// When rsp stalls, the output register holds its beat and the queue absorbs
// further jobs; req stalls only once the queue is full.
// Reset clears frame capture, sets the pending action word to its default,
// empties the queue and restores both registers to their reset values.
`default_nettype none

module door_bus_slave_frame_engine_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dbsfe_in_if.sink      req,
    dbsfe_out_if.source   rsp,
    dbsfe_cfg_if.sink     cfg
);
    import dbsfe_pkg::*;

    logic [7:0] slave_addr_reg;
    logic [7:0] dev_type_reg;
    q_wr_t      q_wr;
    q_head_t    q_head;
    logic       q_full;
    logic       pop;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RST;
            dev_type_reg   <= DEV_TYPE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SLAVE_ADDR: slave_addr_reg <= cfg.data;
                REG_DEV_TYPE:   dev_type_reg   <= cfg.data;
                default:        ;
            endcase
        end
    end

    dbsfe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .slave_address (slave_addr_reg),
        .q_full        (q_full),
        .q_wr          (q_wr)
    );

    dbsfe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_head (q_head),
        .pop    (pop)
    );

    dbsfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .pop           (pop),
        .slave_address (slave_addr_reg),
        .device_type   (dev_type_reg),
        .rsp           (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/core/dbsfe_front.sv -----
// Front end: frame capture, CRC check, frame decode and pending action word.
`default_nettype none

module dbsfe_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    dbsfe_in_if.sink             req,
    input  wire logic [7:0]      slave_address,
    input  wire logic            q_full,
    output dbsfe_pkg::q_wr_t     q_wr
);
    import dbsfe_pkg::*;

    logic        capturing_reg, capturing_next;
    logic [4:0]  pos_reg, pos_next;
    logic [4:0]  len_reg, len_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] pending_reg, pending_next;
    logic [7:0]  hdr_reg [HDR_DEPTH];

    logic        accept;
    logic        take_byte;
    logic [7:0]  crc_new;
    logic [4:0]  pos_inc;
    logic        frame_end;
    logic [3:0]  nib;
    logic [3:0]  roll;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign take_byte = accept && (req.cmd == CMD_BYTE) && !req.framing_error && capturing_reg;
    assign crc_new   = crc8_next(crc_reg, req.rx_byte);
    assign pos_inc   = pos_reg + 5'd1;
    assign frame_end = take_byte && (pos_inc != POS_LENGTH) && (pos_inc == len_reg);
    assign nib       = hdr_reg[1][3:0];
    assign roll      = hdr_reg[1][7:4] + 4'd1;

    // Capture state, CRC, action triggers and decode of a finished frame.
    always_comb
    begin
        capturing_next = capturing_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        pending_next   = pending_reg;
        q_wr.push      = 1'b0;
        q_wr.job.kind  = JOB_BCAST;
        q_wr.job.roll  = roll;
        q_wr.job.word  = {hdr_reg[3], hdr_reg[2]};

        if (accept && (req.cmd == CMD_TRIGGER))
        begin
            case (req.action)
                ACT_STOP:  pending_next = WORD_STOP;
                ACT_OPEN:  pending_next = WORD_OPEN;
                ACT_CLOSE: pending_next = WORD_CLOSE;
                ACT_VENT:  pending_next = WORD_VENT;
                ACT_LIGHT: pending_next = WORD_LIGHT;
                default:   pending_next = pending_reg;
            endcase
        end
        else if (accept && req.framing_error)
        begin
            capturing_next = 1'b1;
            pos_next       = 5'd0;
            len_next       = 5'd0;
            crc_next       = CRC_INIT;
        end
        else if (take_byte)
        begin
            crc_next = crc_new;
            pos_next = pos_inc;
            if (pos_inc == POS_LENGTH)
            begin
                len_next = {1'b0, req.rx_byte[3:0]} + LEN_OVERHEAD;
            end
            else if (frame_end)
            begin
                capturing_next = 1'b0;
            end
        end

        // Act on an accepted frame in the beat of its last byte.
        if (frame_end && (crc_new == 8'h00))
        begin
            if (hdr_reg[0] == BCAST_ADDRESS)
            begin
                if (nib == LEN_BCAST)
                begin
                    q_wr.push     = 1'b1;
                    q_wr.job.kind = JOB_BCAST;
                end
            end
            else if (hdr_reg[0] == slave_address)
            begin
                if ((nib == LEN_SCAN) && (hdr_reg[2] == OP_SCAN))
                begin
                    q_wr.push     = 1'b1;
                    q_wr.job.kind = JOB_SCAN;
                end
                else if ((nib == LEN_STATUS) && (hdr_reg[2] == OP_STATUS_REQ))
                begin
                    q_wr.push     = 1'b1;
                    q_wr.job.kind = JOB_STAT;
                    q_wr.job.word = pending_reg;
                    pending_next  = WORD_DEFAULT;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            pos_reg       <= 5'd0;
            len_reg       <= 5'd0;
            crc_reg       <= CRC_INIT;
            pending_reg   <= WORD_DEFAULT;
        end
        else
        begin
            capturing_reg <= capturing_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            pending_reg   <= pending_next;
        end
    end

    // Header bytes, the first four of the frame.
    always_ff @(posedge clk)
    begin
        if (take_byte && (pos_reg < HDR_DEPTH))
        begin
            hdr_reg[pos_reg[1:0]] <= req.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dbsfe_queue.sv -----
// Short job queue between the frame decoder and the reply sequencer.
`default_nettype none

module dbsfe_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dbsfe_pkg::q_wr_t q_wr,
    output logic                  q_full,
    output dbsfe_pkg::q_head_t    q_head,
    input  wire logic             pop
);
    import dbsfe_pkg::*;

    job_t              mem [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_full       = (count_reg == QCNT_W'(QDEPTH));
    assign do_push      = q_wr.push && !q_full;
    assign do_pop       = pop && (count_reg != '0);
    assign q_head.valid = (count_reg != '0);
    assign q_head.job   = mem[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wr.job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("job queue occupancy above its depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full)
        else $error("job pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_head.valid)
        else $error("pop from an empty job queue");

endmodule

`default_nettype wire

// ----- rtl/core/dbsfe_back.sv -----
// Back end: turns queued jobs into reply bytes with CRC or a status beat.
`default_nettype none

module dbsfe_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dbsfe_pkg::q_head_t q_head,
    output logic                    pop,
    input  wire logic [7:0]         slave_address,
    input  wire logic [7:0]         device_type,
    dbsfe_out_if.source             rsp
);
    import dbsfe_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic [7:0]  crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [7:0]  tx_reg;
    logic [15:0] word_reg;
    logic        last_reg;

    logic        advance;
    logic [7:0]  crc_cur;
    logic [2:0]  end_step;
    logic        is_end;
    logic [7:0]  msg_byte;
    logic        b_kind;
    logic [7:0]  b_tx;
    logic [15:0] b_word;

    assign advance  = q_head.valid && (!out_valid_reg || rsp.ready);
    assign crc_cur  = (step_reg == STEP_FIRST) ? CRC_INIT : crc_reg;
    assign end_step = (q_head.job.kind == JOB_SCAN) ? STEP_SCAN_END : STEP_STAT_END;
    assign is_end   = (q_head.job.kind == JOB_BCAST) || (step_reg == end_step);
    assign pop      = advance && is_end;

    // Reply message byte for the current step.
    always_comb
    begin
        case (step_reg)
            STEP_FIRST: msg_byte = HOST_ADDRESS;
            STEP_LEN:   msg_byte = {q_head.job.roll,
                                    (q_head.job.kind == JOB_SCAN) ? SCAN_LEN_CODE
                                                                  : STAT_LEN_CODE};
            STEP_OP:    msg_byte = (q_head.job.kind == JOB_SCAN) ? device_type
                                                                 : OP_STATUS_RESP;
            STEP_DATA0: msg_byte = (q_head.job.kind == JOB_SCAN) ? slave_address
                                                                 : q_head.job.word[7:0];
            STEP_DATA1: msg_byte = q_head.job.word[15:8];
            default:    msg_byte = 8'h00;
        endcase
    end

    // Beat contents and sequencer update.
    always_comb
    begin
        b_kind         = KIND_REPLY;
        b_tx           = msg_byte;
        b_word         = 16'h0000;
        step_next      = step_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (q_head.job.kind == JOB_BCAST)
        begin
            b_kind = KIND_STATUS;
            b_tx   = 8'h00;
            b_word = q_head.job.word;
        end
        else if (is_end)
        begin
            b_tx = crc_cur;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            if (is_end)
            begin
                step_next = STEP_FIRST;
            end
            else
            begin
                step_next = step_reg + 3'd1;
                crc_next  = crc8_next(crc_cur, msg_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_FIRST;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register; holds while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= b_kind;
            tx_reg   <= b_tx;
            word_reg <= b_word;
            last_reg <= is_end;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = kind_reg;
    assign rsp.tx_byte     = tx_reg;
    assign rsp.status_word = word_reg;
    assign rsp.last        = last_reg;

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == KIND_STATUS) |-> rsp.last)
        else $error("status beat without last");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_STAT_END)
        else $error("reply sequencer step out of range");

    a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (step_reg == STEP_FIRST))
        else $error("sequencer did not restart after a job");

endmodule

`default_nettype wire
